[sv/sbusd_pkg.sv]
// Package: shared types, constants and helpers for the S.BUS frame decoder.
package sbusd_pkg;

  localparam int FRAME_LEN  = 25;
  localparam int STORE_LEN  = FRAME_LEN - 1;
  localparam int COUNT_W    = $clog2(FRAME_LEN + 1);

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] DEAD_ZONE_RESET = 8'd5;

  localparam logic signed [12:0] STICK_OFFSET = 13'sd368;
  localparam logic signed [12:0] STICK_C_BASE = 13'sd1680;
  localparam logic signed [12:0] BAND_LO      = 13'sd550;
  localparam logic signed [12:0] BAND_HI      = 13'sd750;
  localparam logic signed [12:0] BAND_MID     = 13'sd650;
  localparam logic signed [12:0] ABOVE_SUB    = 13'sd236;
  localparam logic signed [10:0] OUT_BIAS     = 11'sd255;

  // floor(m/d) = (m * ceil(2^k/d)) >> k over the operand ranges used here
  localparam logic [15:0] RECIP_11   = 16'd47663;   // k = 19
  localparam int          SHIFT_11   = 19;
  localparam logic [18:0] RECIP_41   = 19'd204601;  // k = 23, span 1312 = 32 * 41
  localparam int          SHIFT_41   = 23;
  localparam logic [18:0] RECIP_659  = 19'd407338;  // k = 28, span 1318 = 2 * 659
  localparam int          SHIFT_659  = 28;

  localparam logic [10:0] SW_RAW_LOW = 11'd144;
  localparam logic [10:0] SW_RAW_MID = 11'd1024;

  localparam logic [1:0] SW_POS_LOW   = 2'd0;
  localparam logic [1:0] SW_POS_MID   = 2'd1;
  localparam logic [1:0] SW_POS_OTHER = 2'd2;

  localparam logic [1:0] STICK_C_SEL = 2'd2;
  localparam logic [1:0] STICK_D_SEL = 2'd3;

  typedef logic signed [9:0] stick_t;
  typedef logic [1:0]        sw_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_DIV1,
    STEP_MID,
    STEP_DIV2,
    STEP_OUT
  } step_e;

  typedef struct packed {
    logic       shift;
    step_e      step;
    logic [1:0] sel;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_header;
  } dp_status_t;

  function automatic sw_t sw_pos(input logic [10:0] raw);
    sw_t pos;
    if (raw == SW_RAW_LOW) begin
      pos = SW_POS_LOW;
    end else if (raw == SW_RAW_MID) begin
      pos = SW_POS_MID;
    end else begin
      pos = SW_POS_OTHER;
    end
    return pos;
  endfunction

endpackage

[sv/sbusd_ctrl.sv]
// Controller: byte count, frame hunting, stick scaling sequence and output handshake.
module sbusd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sbusd_pkg::dp_status_t status_i,
  output sbusd_pkg::dp_cmd_t    cmd_o
);
  import sbusd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [COUNT_W-1:0]   count_q;
  step_e                step_q;
  logic [1:0]           sel_q;
  logic                 out_valid_q;

  logic accept;
  logic load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign cmd_o.shift    = accept && (count_q != '0);
  assign cmd_o.step     = step_q;
  assign cmd_o.sel      = sel_q;
  assign cmd_o.out_load = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= STEP_NONE;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (count_q == '0) begin
              if (status_i.is_header) begin
                count_q <= COUNT_W'(1);
              end
            end else if (count_q == COUNT_W'(FRAME_LEN - 1)) begin
              count_q <= '0;
              state_q <= ST_CALC;
              step_q  <= STEP_LOAD;
              sel_q   <= '0;
            end else begin
              count_q <= count_q + COUNT_W'(1);
            end
          end
        end
        ST_CALC: begin
          case (step_q)
            STEP_LOAD: step_q <= STEP_DIV1;
            STEP_DIV1: step_q <= STEP_MID;
            STEP_MID:  step_q <= STEP_DIV2;
            STEP_DIV2: step_q <= STEP_OUT;
            STEP_OUT: begin
              if (sel_q == STICK_D_SEL) begin
                step_q  <= STEP_NONE;
                state_q <= ST_DONE;
              end else begin
                sel_q  <= sel_q + 2'd1;
                step_q <= STEP_LOAD;
              end
            end
            default: step_q <= STEP_NONE;
          endcase
        end
        ST_DONE: begin
          if (load) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/sbusd_datapath.sv]
// Datapath: frame byte store, channel unpack, shared stick scaler, switch decode, output registers.
module sbusd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            rx_byte_i,
  input  logic                  cfg_we_i,
  input  logic [7:0]            dead_zone_i,
  input  sbusd_pkg::dp_cmd_t     cmd_i,
  output sbusd_pkg::dp_status_t  status_o,
  output sbusd_pkg::stick_t      stick_a_o,
  output sbusd_pkg::stick_t      stick_b_o,
  output sbusd_pkg::stick_t      stick_c_o,
  output sbusd_pkg::stick_t      stick_d_o,
  output sbusd_pkg::sw_t         switch_a_o,
  output sbusd_pkg::sw_t         switch_b_o,
  output sbusd_pkg::sw_t         switch_c_o,
  output sbusd_pkg::sw_t         switch_d_o,
  output logic                  failsafe_o
);
  import sbusd_pkg::*;

  // fb_q[k-1] holds frame byte k once the frame is complete
  logic [7:0]  fb_q [STORE_LEN];
  logic [7:0]  dz_q;
  sw_t         held_c_q, held_d_q;
  stick_t      st_q [4];

  logic [14:0]        m1_q;
  logic               neg1_q, band_q, above_q;
  logic [10:0]        q1_q;
  logic [19:0]        m2_q;
  logic               neg2_q;
  logic [9:0]         q2_q;

  stick_t stick_a_q, stick_b_q, stick_c_q, stick_d_q;
  sw_t    sw_a_q, sw_b_q, sw_c_q, sw_d_q;
  logic   fs_q;

  logic [10:0] ch [8];
  logic        fs;
  logic [10:0] ch_sel;

  logic signed [12:0] v_full;
  logic [10:0]        mag1;
  logic [14:0]        m1_d;
  logic [30:0]        p1;
  logic signed [12:0] q1s, v2;
  logic [10:0]        mag2;
  logic [19:0]        m2_d;
  logic [18:0]        op2, rc2;
  logic [37:0]        p2;
  logic [9:0]         q2_d;
  logic signed [10:0] q2s, o, dzs;
  stick_t             o_fin;

  assign status_o.is_header = (rx_byte_i == HEADER_BYTE);

  always_comb begin
    ch[0] = {fb_q[1][2:0], fb_q[0]};
    ch[1] = {fb_q[2][5:0], fb_q[1][7:3]};
    ch[2] = {fb_q[4][0], fb_q[3], fb_q[2][7:6]};
    ch[3] = {fb_q[5][3:0], fb_q[4][7:1]};
    ch[4] = {fb_q[6][6:0], fb_q[5][7:4]};
    ch[5] = {fb_q[8][1:0], fb_q[7], fb_q[6][7]};
    ch[6] = {fb_q[9][4:0], fb_q[8][7:2]};
    ch[7] = {fb_q[10], fb_q[9][7:5]};
    fs    = fb_q[22][3];
  end

  // stick scaler, one step per cycle
  always_comb begin
    ch_sel = ch[{1'b0, cmd_i.sel}];
    if (cmd_i.sel == STICK_C_SEL) begin
      v_full = STICK_C_BASE - $signed({2'b00, ch_sel});
    end else begin
      v_full = $signed({2'b00, ch_sel}) - STICK_OFFSET;
    end
    mag1 = v_full[12] ? 11'(-v_full) : v_full[10:0];
    m1_d = {4'b0000, mag1} * 15'd13;

    p1 = {16'b0, m1_q} * {15'b0, RECIP_11};

    q1s = $signed({2'b00, q1_q});
    if (band_q) begin
      v2 = BAND_MID;
    end else begin
      v2 = neg1_q ? -q1s : q1s;
      if (above_q) begin
        v2 = v2 - ABOVE_SUB;
      end
    end
    mag2 = v2[12] ? 11'(-v2) : v2[10:0];
    m2_d = {9'b0, mag2} * 20'd510;

    if (cmd_i.sel == STICK_D_SEL) begin
      op2 = m2_q[19:1];
      rc2 = RECIP_659;
    end else begin
      op2 = {4'b0000, m2_q[19:5]};
      rc2 = RECIP_41;
    end
    p2 = {19'b0, op2} * {19'b0, rc2};
    q2_d = (cmd_i.sel == STICK_D_SEL) ? p2[SHIFT_659 +: 10] : p2[SHIFT_41 +: 10];

    q2s = $signed({1'b0, q2_q});
    o   = (neg2_q ? -q2s : q2s) - OUT_BIAS;
    dzs = $signed({3'b000, dz_q});
    o_fin = ((o <= dzs) && (o >= -dzs)) ? '0 : o[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q     <= DEAD_ZONE_RESET;
      held_c_q <= SW_POS_LOW;
      held_d_q <= SW_POS_LOW;
    end else begin
      if (cfg_we_i) begin
        dz_q <= dead_zone_i;
      end
      if (cmd_i.out_load && !fs) begin
        held_c_q <= sw_pos(ch[6]);
        held_d_q <= sw_pos(ch[7]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      fb_q[STORE_LEN-1] <= rx_byte_i;
      for (int i = 0; i < STORE_LEN - 1; i++) begin
        fb_q[i] <= fb_q[i+1];
      end
    end
    case (cmd_i.step)
      STEP_LOAD: begin
        m1_q    <= m1_d;
        neg1_q  <= v_full[12];
        band_q  <= (v_full >= BAND_LO) && (v_full <= BAND_HI);
        above_q <= (v_full > BAND_HI);
      end
      STEP_DIV1: q1_q <= p1[SHIFT_11 +: 11];
      STEP_MID: begin
        m2_q   <= m2_d;
        neg2_q <= v2[12];
      end
      STEP_DIV2: q2_q <= q2_d;
      STEP_OUT:  st_q[cmd_i.sel] <= o_fin;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      fs_q <= fs;
      if (fs) begin
        stick_a_q <= '0;
        stick_b_q <= '0;
        stick_c_q <= '0;
        stick_d_q <= '0;
        sw_a_q    <= SW_POS_LOW;
        sw_b_q    <= SW_POS_LOW;
        sw_c_q    <= held_c_q;
        sw_d_q    <= held_d_q;
      end else begin
        stick_a_q <= st_q[0];
        stick_b_q <= st_q[1];
        stick_c_q <= st_q[2];
        stick_d_q <= st_q[3];
        sw_a_q    <= sw_pos(ch[4]);
        sw_b_q    <= sw_pos(ch[5]);
        sw_c_q    <= sw_pos(ch[6]);
        sw_d_q    <= sw_pos(ch[7]);
      end
    end
  end

  assign stick_a_o  = stick_a_q;
  assign stick_b_o  = stick_b_q;
  assign stick_c_o  = stick_c_q;
  assign stick_d_o  = stick_d_q;
  assign switch_a_o = sw_a_q;
  assign switch_b_o = sw_b_q;
  assign switch_c_o = sw_c_q;
  assign switch_d_o = sw_d_q;
  assign failsafe_o = fs_q;

endmodule

[sv/sbus_frame_decoder_top.sv]
// Timing: after the last byte of a frame is accepted, the four sticks are scaled in turn and the
// result is loaded into the output register, later if the previous result has not yet been taken.
// Throughput: one byte per cycle while a frame is received; after the last byte the
// input stalls while the sticks are scaled (one shared scaler, 5 steps per stick) plus any output wait.
// Reset (async, active low): hunting for header, output empty, dead zone 5, held switches 0.
// Top level: S.BUS frame decoder.
module sbus_frame_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          dead_zone_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbusd_pkg::stick_t   stick_a_o,
  output sbusd_pkg::stick_t   stick_b_o,
  output sbusd_pkg::stick_t   stick_c_o,
  output sbusd_pkg::stick_t   stick_d_o,
  output sbusd_pkg::sw_t      switch_a_o,
  output sbusd_pkg::sw_t      switch_b_o,
  output sbusd_pkg::sw_t      switch_c_o,
  output sbusd_pkg::sw_t      switch_d_o,
  output logic                failsafe_o
);
  import sbusd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sbusd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbusd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .dead_zone_i (dead_zone_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .stick_a_o   (stick_a_o),
    .stick_b_o   (stick_b_o),
    .stick_c_o   (stick_c_o),
    .stick_d_o   (stick_d_o),
    .switch_a_o  (switch_a_o),
    .switch_b_o  (switch_b_o),
    .switch_c_o  (switch_c_o),
    .switch_d_o  (switch_d_o),
    .failsafe_o  (failsafe_o)
  );

endmodule
